[hdl/cmm_pkg.sv]
`default_nettype none
package cmm_pkg;

	// field widths fixed by the item formats
	localparam int KIND_W = 2;
	localparam int ROW_W  = 3;
	localparam int PART_W = 16;
	localparam int ACC_W  = 40;
	localparam int DIM_W  = 4;

	// input item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_START  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// one input beat
	typedef struct packed {
		kind_t                     kind;
		logic [ROW_W-1:0]          row;
		logic [ROW_W-1:0]          col;
		logic signed [PART_W-1:0]  real_part;
		logic signed [PART_W-1:0]  imag_part;
	} in_item_t;

	// one result beat
	typedef struct packed {
		logic [ROW_W-1:0]          out_row;
		logic [ROW_W-1:0]          out_col;
		logic signed [ACC_W-1:0]   out_real;
		logic signed [ACC_W-1:0]   out_imag;
		logic                      last;
	} out_item_t;

	// sequencer to multiply-accumulate unit
	typedef struct packed {
		logic vld;      // operands valid this cycle
		logic to_imag;  // product goes to the imaginary sum
		logic neg;      // subtract the product
		logic clr;      // clear both sums
	} mac_ctl_t;

endpackage
`default_nettype wire

[hdl/cmm_mac.sv]
`default_nettype none
module cmm_mac #(
	parameter int EW = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmm_pkg::mac_ctl_t                ctl,
	input  logic signed [EW-1:0]             op_a,
	input  logic signed [EW-1:0]             op_b,
	output logic signed [cmm_pkg::ACC_W-1:0] acc_re,
	output logic signed [cmm_pkg::ACC_W-1:0] acc_im
);
	import cmm_pkg::*;

	logic                    vld_s1;
	logic                    imag_s1;
	logic                    neg_s1;
	logic signed [2*EW-1:0]  prod_s1;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;

	// product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		imag_s1 <= ctl.to_imag;
		neg_s1  <= ctl.neg;
	end

	// sign extend and apply the sign of the term
	assign addend = ACC_W'(prod_s1);
	assign term   = neg_s1 ? -addend : addend;

	// accumulate into real or imaginary sum
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (vld_s1) begin
			if (imag_s1) begin
				acc_im_q <= acc_im_q + term;
			end else begin
				acc_re_q <= acc_re_q + term;
			end
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;

endmodule
`default_nettype wire

[hdl/complex_matrix_multiply_unit.sv]
`default_nettype none
// Complex square matrix multiplier. Load beats write one element of A or B
// (real and imaginary parts, signed fixed point) at row/col; writes outside
// the store are dropped. A start beat forms P = A * B over the leading
// n-by-n corner, n = min(dimension, MAX_DIM), and sends n*n results in
// row-major order with exact 40-bit sums and last on the final entry; with
// n = 0 it sends nothing. Loads are taken one per cycle while idle. A start
// runs on a single EW-by-EW multiplier, EW = min(ELEM_BITS, 16), that runs
// four passes per complex product after each store read; an output stall
// holds the work. No beat is taken while a product is in progress. Entries
// that were never written read as unknown values. dimension may only be
// written while the unit is idle and all results have been taken.
module complex_matrix_multiply_unit #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  cmm_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output cmm_pkg::out_item_t            result,
	input  logic                          dim_we,
	input  logic [cmm_pkg::DIM_W-1:0]     dim_wdata
);
	import cmm_pkg::*;

	localparam int EW    = (ELEM_BITS < PART_W) ? ELEM_BITS : PART_W;
	localparam int SW    = 2 * EW;
	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_MUL   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    dim_q;
	logic [DIM_W-1:0]    n_sat;
	logic [IW-1:0]       last_idx_q;
	logic [IW-1:0]       i_q;
	logic [IW-1:0]       j_q;
	logic [IW-1:0]       k_q;
	logic [1:0]          phase_q;
	logic                item_take;
	logic                start_take;
	logic                wr_ok;
	logic                wr_a;
	logic                wr_b;
	logic [AW-1:0]       wr_addr;
	logic [SW-1:0]       wr_word;
	logic                rd_en;
	logic [AW-1:0]       rd_addr_a;
	logic [AW-1:0]       rd_addr_b;
	logic [SW-1:0]       store_a_q [Depth];
	logic [SW-1:0]       store_b_q [Depth];
	logic [SW-1:0]       rd_a_q;
	logic [SW-1:0]       rd_b_q;
	logic signed [EW-1:0] op_a;
	logic signed [EW-1:0] op_b;
	mac_ctl_t            mac_ctl;
	logic signed [ACC_W-1:0] acc_re;
	logic signed [ACC_W-1:0] acc_im;
	logic                emit_load;
	logic                row_done;
	logic                all_done;
	logic                result_valid_q;
	out_item_t           result_q;

	// dimension register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_W'(4);
		end else if (dim_we) begin
			dim_q <= dim_wdata;
		end
	end

	assign n_sat = (dim_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q;

	// input handshake
	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign start_take = item_take && (item.kind == KIND_START) && (n_sat != '0);

	// element writes
	assign wr_ok   = ({1'b0, item.row} < (ROW_W + 1)'(MAX_DIM)) &&
		({1'b0, item.col} < (ROW_W + 1)'(MAX_DIM));
	assign wr_a    = item_take && wr_ok && (item.kind == KIND_LOAD_A);
	assign wr_b    = item_take && wr_ok && (item.kind == KIND_LOAD_B);
	assign wr_addr = AW'(32'(item.row) * MAX_DIM + 32'(item.col));
	assign wr_word = {item.imag_part[EW-1:0], item.real_part[EW-1:0]};

	// store reads: A[i][k] and B[k][j]
	assign rd_en     = (state_q == S_READ);
	assign rd_addr_a = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign rd_addr_b = AW'(32'(k_q) * MAX_DIM + 32'(j_q));

	// element stores
	always_ff @(posedge clk) begin
		if (wr_a) begin
			store_a_q[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_a_q <= store_a_q[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			store_b_q[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_b_q <= store_b_q[rd_addr_b];
		end
	end

	// operand select: ar*br, -ai*bi, ar*bi, ai*br over four passes
	assign op_a = phase_q[0] ? $signed(rd_a_q[SW-1:EW]) : $signed(rd_a_q[EW-1:0]);
	assign op_b = (phase_q[0] ^ phase_q[1]) ? $signed(rd_b_q[SW-1:EW]) :
		$signed(rd_b_q[EW-1:0]);

	assign row_done  = (j_q == last_idx_q);
	assign all_done  = row_done && (i_q == last_idx_q);
	assign emit_load = (state_q == S_EMIT) && (!result_valid_q || !result_stall);

	always_comb begin
		mac_ctl.vld     = (state_q == S_MUL);
		mac_ctl.to_imag = phase_q[1];
		mac_ctl.neg     = (phase_q == 2'd1);
		mac_ctl.clr     = start_take || emit_load;
	end

	cmm_mac #(
		.EW(EW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc_re (acc_re),
		.acc_im (acc_im)
	);

	// sequencer over entries, terms and multiply passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_idx_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			phase_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start_take) begin
						last_idx_q <= IW'(n_sat - DIM_W'(1));
						i_q        <= '0;
						j_q        <= '0;
						k_q        <= '0;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					phase_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						if (k_q == last_idx_q) begin
							state_q <= S_DRAIN;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						k_q <= '0;
						if (all_done) begin
							state_q <= S_IDLE;
						end else begin
							if (row_done) begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
							end else begin
								j_q <= j_q + IW'(1);
							end
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.out_row  <= ROW_W'(i_q);
			result_q.out_col  <= ROW_W'(j_q);
			result_q.out_real <= acc_re;
			result_q.out_imag <= acc_im;
			result_q.last     <= all_done;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a start always begins with the first term of the first entry
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		start_take |=> (state_q == S_READ) && (k_q == '0) && (i_q == '0) && (j_q == '0))
		else $error("start did not begin at the first term");

	// indices stay inside the active corner while busy
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (i_q <= last_idx_q) && (j_q <= last_idx_q) &&
		(k_q <= last_idx_q))
		else $error("index beyond active dimension");

	// the fourth pass ends a term: next term or drain
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) && (phase_q == 2'd3) |=> (state_q == S_READ) ||
		(state_q == S_DRAIN))
		else $error("multiply passes out of order");

	// drain hands the finished sums to the emit step
	a_drain_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (state_q == S_EMIT) && (k_q == last_idx_q))
		else $error("drain not followed by emit");

endmodule
`default_nettype wire

[tb/sv/complex_matrix_multiply_unit_tb.sv]
module complex_matrix_multiply_unit_tb;
	import cmm_pkg::*;

	localparam int MAX_DIM      = 8;
	localparam int ELEM_BITS    = 16;
	localparam int PART_BITS    = (ELEM_BITS < PART_W) ? ELEM_BITS : PART_W;
	localparam int STORE_WORDS  = MAX_DIM * MAX_DIM;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE       = 16;
	localparam int REPORT_CAP   = 40;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result;
	logic                dim_we       = 1'b0;
	logic [DIM_W-1:0]    dim_wdata    = '0;

	// stimulus waiting for the driver and products waiting for the monitor
	in_item_t  pending_items[$];
	out_item_t product_entries[$];

	// shadow of the unit: element stores and the dimension register
	logic signed [PART_W-1:0] a_re[STORE_WORDS];
	logic signed [PART_W-1:0] a_im[STORE_WORDS];
	logic signed [PART_W-1:0] b_re[STORE_WORDS];
	logic signed [PART_W-1:0] b_im[STORE_WORDS];
	int dim_setting = 4;

	// entries the stimulus has written so far, so no start reads an empty one
	bit a_seen[STORE_WORDS];
	bit b_seen[STORE_WORDS];

	int  loaded_count   = 0;
	int  mismatch_count = 0;
	int  idle_left      = 0;
	int  stall_left     = 0;
	bit  steady         = 1'b0;

	complex_matrix_multiply_unit #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.dim_we       (dim_we),
		.dim_wdata    (dim_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the unit hangs
	initial begin
		#200_000_000;
		$display("complex_matrix_multiply_unit_tb: FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (mismatch_count < REPORT_CAP)
			$display("complex_matrix_multiply_unit_tb: mismatch: %s", what);
		mismatch_count++;
	endtask

	// element part as the unit reads it: low bits, sign extended
	function automatic longint widen_part(input logic signed [PART_W-1:0] p);
		longint v;
		v = p;
		return (v <<< (64 - PART_BITS)) >>> (64 - PART_BITS);
	endfunction

	// expected entries of P = A * B over the active corner
	function automatic void push_product();
		int n;
		int ia, ib;
		longint sum_re, sum_im, ar, ai, br, bi;
		out_item_t e;
		n = (dim_setting > MAX_DIM) ? MAX_DIM : dim_setting;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				sum_re = 0;
				sum_im = 0;
				for (int k = 0; k < n; k++) begin
					ia = i * MAX_DIM + k;
					ib = k * MAX_DIM + j;
					ar = widen_part(a_re[ia]);
					ai = widen_part(a_im[ia]);
					br = widen_part(b_re[ib]);
					bi = widen_part(b_im[ib]);
					sum_re += ar * br - ai * bi;
					sum_im += ar * bi + ai * br;
				end
				e.out_row  = ROW_W'(i);
				e.out_col  = ROW_W'(j);
				e.out_real = sum_re[ACC_W-1:0];
				e.out_imag = sum_im[ACC_W-1:0];
				e.last     = (i == n - 1) && (j == n - 1);
				product_entries = {product_entries, e};
			end
		end
	endfunction

	// shadow update for one accepted input beat
	function automatic void absorb_item(input in_item_t it);
		int addr;
		addr = it.row * MAX_DIM + it.col;
		case (it.kind)
			KIND_LOAD_A: begin
				a_re[addr] = it.real_part;
				a_im[addr] = it.imag_part;
			end
			KIND_LOAD_B: begin
				b_re[addr] = it.real_part;
				b_im[addr] = it.imag_part;
			end
			KIND_START: begin
				push_product();
			end
			default: begin
			end
		endcase
	endfunction

	// input driver: holds a stalled beat, otherwise idles in bursts or sends the next
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			idle_left = 0;
		end else begin
			if (item_valid && !item_stall)
				absorb_item(item);
			if (item_valid && item_stall) begin
				// keep the stalled beat as it is
			end else if (idle_left > 0) begin
				idle_left--;
				item_valid <= 1'b0;
			end else if (!steady && $urandom_range(0, 15) == 0) begin
				idle_left = $urandom_range(1, 18) - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor: checks each accepted beat and stalls in bursts
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (product_entries.size() == 0) begin
					flag_mismatch($sformatf("unexpected result at %0d,%0d",
						result.out_row, result.out_col));
				end else begin
					want = product_entries.pop_front();
					if (result.out_row !== want.out_row)
						flag_mismatch($sformatf("entry %0d,%0d row: got %0d",
							want.out_row, want.out_col, result.out_row));
					if (result.out_col !== want.out_col)
						flag_mismatch($sformatf("entry %0d,%0d col: got %0d",
							want.out_row, want.out_col, result.out_col));
					if (result.out_real !== want.out_real)
						flag_mismatch($sformatf("entry %0d,%0d real: got %0d want %0d",
							want.out_row, want.out_col, result.out_real, want.out_real));
					if (result.out_imag !== want.out_imag)
						flag_mismatch($sformatf("entry %0d,%0d imag: got %0d want %0d",
							want.out_row, want.out_col, result.out_imag, want.out_imag));
					if (result.last !== want.last)
						flag_mismatch($sformatf("entry %0d,%0d last: got %b want %b",
							want.out_row, want.out_col, result.last, want.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!steady && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// element part with extra weight on the extremes
	function automatic logic signed [PART_W-1:0] pick_part();
		case ($urandom_range(0, 7))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return '0;
			3:       return -16'sd1;
			default: return PART_W'($urandom);
		endcase
	endfunction

	task automatic queue_item(input kind_t k, input int r, input int c,
			input logic signed [PART_W-1:0] re, input logic signed [PART_W-1:0] im);
		in_item_t it;
		it.kind      = k;
		it.row       = ROW_W'(r);
		it.col       = ROW_W'(c);
		it.real_part = re;
		it.imag_part = im;
		pending_items = {pending_items, it};
		if (k != KIND_NONE)
			loaded_count++;
		if (k == KIND_LOAD_A)
			a_seen[r * MAX_DIM + c] = 1'b1;
		if (k == KIND_LOAD_B)
			b_seen[r * MAX_DIM + c] = 1'b1;
	endtask

	task automatic queue_noise();
		queue_item(KIND_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
			pick_part(), pick_part());
	endtask

	// start beat, preceded by loads of any corner entry not yet written
	task automatic queue_start();
		int n;
		n = (dim_setting > MAX_DIM) ? MAX_DIM : dim_setting;
		for (int i = 0; i < n; i++)
			for (int k = 0; k < n; k++) begin
				if (!a_seen[i * MAX_DIM + k])
					queue_item(KIND_LOAD_A, i, k, pick_part(), pick_part());
				if (!b_seen[i * MAX_DIM + k])
					queue_item(KIND_LOAD_B, i, k, pick_part(), pick_part());
			end
		queue_item(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7),
			pick_part(), pick_part());
	endtask

	// sender holds off until every beat is in and every product is out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || product_entries.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_dimension(input int v);
		@(posedge clk);
		dim_we    <= 1'b1;
		dim_wdata <= DIM_W'(v);
		@(posedge clk);
		dim_we    <= 1'b0;
		dim_setting = v;
		@(negedge clk);
	endtask

	// mostly small sizes, sometimes large, zero or above the store size
	function automatic int pick_dimension();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return $urandom_range(1, 4);
		else if (r < 16)
			return $urandom_range(5, 8);
		else if (r < 18)
			return $urandom_range(9, 15);
		return 0;
	endfunction

	initial begin
		int first_random;
		int jobs;
		int loads;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset dimension: ignored kind, a load far outside the corner, extreme corner
		queue_noise();
		queue_item(KIND_LOAD_A, 7, 7, -16'sd32768, 16'sd32767);
		queue_item(KIND_LOAD_B, 7, 7, 16'sd32767, -16'sd32768);
		queue_start();
		wait_drained();

		// single element products at the extremes
		set_dimension(1);
		queue_item(KIND_LOAD_A, 0, 0, 16'sd32767, 16'sd32767);
		queue_item(KIND_LOAD_B, 0, 0, 16'sd32767, 16'sd32767);
		queue_start();
		queue_item(KIND_LOAD_A, 0, 0, -16'sd32768, -16'sd32768);
		queue_item(KIND_LOAD_B, 0, 0, -16'sd32768, -16'sd32768);
		queue_start();
		queue_noise();
		queue_item(KIND_LOAD_A, 0, 0, -16'sd32768, 16'sd32767);
		queue_item(KIND_LOAD_B, 0, 0, 16'sd32767, -16'sd32768);
		queue_start();
		queue_item(KIND_LOAD_A, 0, 0, 16'sd0, -16'sd1);
		queue_item(KIND_LOAD_B, 0, 0, -16'sd1, 16'sd0);
		queue_start();
		wait_drained();

		// zero dimension sends nothing
		set_dimension(0);
		queue_start();
		queue_noise();
		wait_drained();

		// above the store size saturates; uses the far corner loaded earlier
		set_dimension(15);
		queue_start();
		wait_drained();

		// random jobs: loads anywhere in the store, some noise, then a start
		first_random = loaded_count;
		while (loaded_count - first_random < RANDOM_ITEMS) begin
			if (loaded_count - first_random > RANDOM_ITEMS * 4 / 5)
				steady = 1'b1;
			set_dimension(pick_dimension());
			jobs = $urandom_range(1, 4);
			repeat (jobs) begin
				loads = $urandom_range(0, 10);
				repeat (loads) begin
					if ($urandom_range(0, 9) == 0)
						queue_noise();
					else
						queue_item($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
							$urandom_range(0, 7), $urandom_range(0, 7),
							pick_part(), pick_part());
				end
				queue_start();
			end
			wait_drained();
		end

		repeat (100) @(negedge clk);
		if (mismatch_count == 0)
			$display("complex_matrix_multiply_unit_tb: PASS");
		else
			$display("complex_matrix_multiply_unit_tb: FAIL");
		$finish;
	end

endmodule
